@@ hdl/impq_pkg.sv @@
// Package for the indexed max priority queue: item types, command and status codes,
// controller/datapath command and status bundles. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package impq_pkg;
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_EXTRACT = 2'd1;
  localparam logic [1:0] CMD_CHANGE  = 2'd2;
  localparam logic [1:0] CMD_READ    = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_PRESENT = 3'd4;

  // heap read address select
  localparam logic [2:0] HA_K      = 3'd0;
  localparam logic [2:0] HA_PARENT = 3'd1;
  localparam logic [2:0] HA_LEFT   = 3'd2;
  localparam logic [2:0] HA_RIGHT  = 3'd3;
  localparam logic [2:0] HA_ROOT   = 3'd4;
  localparam logic [2:0] HA_LAST   = 3'd5;

  typedef struct packed {
    logic [1:0]         command;
    logic [5:0]         entry_number;
    logic signed [31:0] key_in;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] key_out;
    logic [5:0]         entry_out;
  } rsp_t;

  // one heap slot: entry number and its key
  typedef struct packed {
    logic [5:0]         ent;
    logic signed [31:0] key;
  } node_t;

  // controller -> datapath
  typedef struct packed {
    logic       clear;      // zero one entry position (pass after reset)
    logic       load;       // capture request
    logic       classify;   // register status, key_out and entry_out defaults
    logic       ins_setup;  // grow heap, sift node from the new last slot
    logic       pos_setup;  // sift node from the entry's current slot
    logic [2:0] h_addr;     // heap read address select
    logic       cap_top;    // take root as result, mark its entry absent
    logic       cap_last;   // shrink heap, last slot becomes the node at root
    logic       cap_left;   // hold left child
    logic       cap_key;    // take read key as result
    logic       up_step;    // parent moves down into the hole
    logic       dn_step;    // larger child moves up into the hole
    logic       place;      // write node into the hole
    logic       respond;    // drive result strobe
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic       clr_done;  // last entry position being cleared
    logic       bad;       // item ends with an error status
    logic [1:0] command;
    logic       up_end;    // node at root
    logic       up_go;     // parent key smaller than node key
    logic       dn_end;    // node has no children
    logic       dn_go;     // node not strictly larger than larger child
    logic       one_left;  // heap holds one entry
  } sts_t;
endpackage
`default_nettype wire

@@ hdl/impq_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module impq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/impq_datapath.sv @@
// Datapath: heap slot memory, entry position memory, count and sift registers, compares.
// Depends on impq_pkg and impq_ram.
`timescale 1ns / 1ps
`default_nettype none
module impq_datapath #(
  parameter int CAPACITY = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire impq_pkg::req_t req,
  input  wire impq_pkg::ctl_t ctl,
  output      impq_pkg::sts_t sts,
  output      impq_pkg::rsp_t rsp,
  output      logic           result_valid
);
  import impq_pkg::*;
  localparam int SA = $clog2(CAPACITY + 1);  // slot index and count width
  localparam int SD = 1 << SA;
  localparam int NE = 64;

  req_t               r;
  logic [SA-1:0]      count;
  logic [SA-1:0]      k;       // hole slot of the node being sifted
  node_t              node;    // node kept out of the heap until placed
  node_t              left;
  logic [5:0]         clr;
  logic [2:0]         st;
  logic signed [31:0] kout;
  logic [5:0]         eout;

  // heap slot ram, key held beside the entry number
  logic          h_we;
  logic [SA-1:0] h_wa, h_ra;
  node_t         h_wd, h_rd;
  // entry position ram, 0 = absent
  logic          p_we;
  logic [5:0]    p_wa;
  logic [SA-1:0] p_wd, p_rd;

  impq_ram #(.WIDTH($bits(node_t)), .DEPTH(SD)) u_slots (
    .clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  impq_ram #(.WIDTH(SA), .DEPTH(NE)) u_pos (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(req.entry_number), .rdata(p_rd));

  // child slots, one bit wider than a slot index
  logic [SA:0] kx2, kx2p1, count_x;
  assign kx2     = {k, 1'b0};
  assign kx2p1   = {k, 1'b1};
  assign count_x = {1'b0, count};

  // larger child, right only when strictly larger
  logic          has_right, pick_right;
  node_t         child;
  logic [SA-1:0] child_slot;
  assign has_right  = (kx2p1 <= count_x);
  assign pick_right = has_right && (h_rd.key > left.key);
  assign child      = pick_right ? h_rd : left;
  assign child_slot = pick_right ? kx2p1[SA-1:0] : kx2[SA-1:0];

  // status of the captured request; entry position valid in the cycle after load
  logic       in_range;
  logic [2:0] bad_st;
  assign in_range = (int'(r.entry_number) < CAPACITY);

  always_comb begin
    bad_st = ST_OK;
    case (r.command)
      CMD_EXTRACT: if (count == '0) bad_st = ST_EMPTY;
      CMD_INSERT: begin
        if (!in_range) bad_st = ST_ABSENT;
        else if (p_rd != '0) bad_st = ST_PRESENT;
        else if (count >= SA'(CAPACITY)) bad_st = ST_FULL;
      end
      default: if (!in_range || p_rd == '0) bad_st = ST_ABSENT;
    endcase
  end

  // heap read address
  always_comb begin
    case (ctl.h_addr)
      HA_K:      h_ra = k;
      HA_PARENT: h_ra = {1'b0, k[SA-1:1]};
      HA_LEFT:   h_ra = kx2[SA-1:0];
      HA_RIGHT:  h_ra = kx2p1[SA-1:0];
      HA_ROOT:   h_ra = SA'(1);
      HA_LAST:   h_ra = count;
      default:   h_ra = k;
    endcase
  end

  // memory writes
  always_comb begin
    h_we = 1'b0; h_wa = k; h_wd = node;
    p_we = 1'b0; p_wa = node.ent; p_wd = k;
    if (ctl.clear) begin
      p_we = 1'b1; p_wa = clr; p_wd = '0;
    end else if (ctl.cap_top) begin
      p_we = 1'b1; p_wa = h_rd.ent; p_wd = '0;
    end else if (ctl.up_step) begin
      h_we = 1'b1; h_wd = h_rd;
      p_we = 1'b1; p_wa = h_rd.ent;
    end else if (ctl.dn_step) begin
      h_we = 1'b1; h_wd = child;
      p_we = 1'b1; p_wa = child.ent;
    end else if (ctl.place) begin
      h_we = 1'b1;
      p_we = 1'b1;
    end
  end

  assign sts.clr_done = (clr == 6'(NE - 1));
  assign sts.bad      = (bad_st != ST_OK);
  assign sts.command  = r.command;
  assign sts.up_end   = (k <= SA'(1));
  assign sts.up_go    = (h_rd.key < node.key);
  assign sts.dn_end   = (kx2 > count_x);
  assign sts.dn_go    = !(node.key > child.key);
  assign sts.one_left = (count == SA'(1));

  assign rsp.status    = st;
  assign rsp.key_out   = kout;
  assign rsp.entry_out = eout;

  // count, clear pointer and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      clr <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.respond;
      if (ctl.clear) clr <= clr + 6'd1;
      if (ctl.ins_setup) count <= count + SA'(1);
      else if (ctl.cap_last) count <= count - SA'(1);
    end
  end

  // request, result and sift registers
  always_ff @(posedge clk) begin
    if (ctl.load) r <= req;
    if (ctl.classify) begin
      st <= bad_st; kout <= '0; eout <= r.entry_number;
    end
    if (ctl.ins_setup) begin
      k <= count + SA'(1);
      node.ent <= r.entry_number; node.key <= r.key_in;
    end
    if (ctl.pos_setup) begin
      k <= p_rd;
      node.ent <= r.entry_number; node.key <= r.key_in;
    end
    if (ctl.cap_top) begin
      kout <= h_rd.key; eout <= h_rd.ent;
    end
    if (ctl.cap_last) begin
      node <= h_rd; k <= SA'(1);
    end
    if (ctl.cap_left) left <= h_rd;
    if (ctl.cap_key) kout <= h_rd.key;
    if (ctl.up_step) k <= {1'b0, k[SA-1:1]};
    if (ctl.dn_step) k <= child_slot;
  end
endmodule
`default_nettype wire

@@ hdl/impq_ctrl.sv @@
// Controller state machine for the priority queue: clearing pass, dispatch, sift loops.
// Depends on impq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module impq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output      logic           busy,
  input  wire impq_pkg::sts_t sts,
  output      impq_pkg::ctl_t ctl
);
  import impq_pkg::*;
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CLS   = 4'd2;
  localparam logic [3:0] S_UP    = 4'd3;
  localparam logic [3:0] S_UPC   = 4'd4;
  localparam logic [3:0] S_DN    = 4'd5;
  localparam logic [3:0] S_DNL   = 4'd6;
  localparam logic [3:0] S_DNR   = 4'd7;
  localparam logic [3:0] S_EX1   = 4'd8;
  localparam logic [3:0] S_EX2   = 4'd9;
  localparam logic [3:0] S_EX3   = 4'd10;
  localparam logic [3:0] S_RD    = 4'd11;
  localparam logic [3:0] S_RDW   = 4'd12;
  localparam logic [3:0] S_PLACE = 4'd13;
  localparam logic [3:0] S_RESP  = 4'd14;

  logic [3:0] state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        ctl.clear = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: if (start) begin ctl.load = 1'b1; state_next = S_CLS; end
      S_CLS: begin
        ctl.classify = 1'b1;
        if (sts.bad) state_next = S_RESP;
        else begin
          case (sts.command)
            CMD_INSERT:  begin ctl.ins_setup = 1'b1; state_next = S_UP; end
            CMD_EXTRACT: state_next = S_EX1;
            CMD_CHANGE:  begin ctl.pos_setup = 1'b1; state_next = S_UP; end
            CMD_READ:    begin ctl.pos_setup = 1'b1; state_next = S_RD; end
            default:     state_next = S_RESP;
          endcase
        end
      end
      // sift up: read parent, then move it down while smaller than the node
      S_UP: begin
        ctl.h_addr = HA_PARENT;
        if (sts.up_end) state_next = (sts.command == CMD_CHANGE) ? S_DN : S_PLACE;
        else state_next = S_UPC;
      end
      S_UPC: begin
        if (sts.up_go) begin ctl.up_step = 1'b1; state_next = S_UP; end
        else state_next = (sts.command == CMD_CHANGE) ? S_DN : S_PLACE;
      end
      // sift down: read left, then right, move larger child up unless node wins
      S_DN: begin
        ctl.h_addr = HA_LEFT;
        state_next = sts.dn_end ? S_PLACE : S_DNL;
      end
      S_DNL: begin
        ctl.cap_left = 1'b1;
        ctl.h_addr = HA_RIGHT;
        state_next = S_DNR;
      end
      S_DNR: begin
        if (sts.dn_go) begin ctl.dn_step = 1'b1; state_next = S_DN; end
        else state_next = S_PLACE;
      end
      // extract: read root, read last slot, then sift last down from root unless the heap is now empty
      S_EX1: begin ctl.h_addr = HA_ROOT; state_next = S_EX2; end
      S_EX2: begin ctl.cap_top = 1'b1; ctl.h_addr = HA_LAST; state_next = S_EX3; end
      S_EX3: begin
        ctl.cap_last = 1'b1;
        state_next = sts.one_left ? S_RESP : S_DN;
      end
      S_RD:    begin ctl.h_addr = HA_K; state_next = S_RDW; end
      S_RDW:   begin ctl.cap_key = 1'b1; state_next = S_RESP; end
      S_PLACE: begin ctl.place = 1'b1; state_next = S_RESP; end
      S_RESP:  begin ctl.respond = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end
endmodule
`default_nettype wire

@@ hdl/indexed_max_priority_queue_core.sv @@
// Top level of the indexed max priority queue: controller plus datapath.
// Depends on impq_pkg, impq_ctrl, impq_datapath.
//   channel  signals                 handshake
//   request  start, req (req_t)      taken when start && !busy
//   result   result_valid, rsp       one-cycle strobe, no back-pressure
// One item at a time. An item with an error status goes straight to the response;
// an insert sifts up, an extract sifts down from the root and a change sifts up, then
// down. The result strobe is high in the first cycle in which busy is low again.
// After reset, busy stays high while entry positions are cleared.
// The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module indexed_max_priority_queue_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output      logic           busy,
  input  wire impq_pkg::req_t req,
  output      logic           result_valid,
  output      impq_pkg::rsp_t rsp
);
  import impq_pkg::*;
  ctl_t ctl;
  sts_t sts;
  impq_ctrl u_ctrl (.clk, .rst, .start, .busy, .sts, .ctl);
  impq_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst, .req, .ctl, .sts, .rsp, .result_valid);
endmodule
`default_nettype wire
